/* hw/rtl/urxf_pkg.sv */
// ============================================================================
// urxf_pkg
// Shared types, register map and constants of the uart register file with
// receive fifo.
// ============================================================================
`default_nettype none

package urxf_pkg;

    // sizes
    localparam int unsigned FIFO_DEPTH = 64;
    localparam int unsigned REG_COUNT  = 18;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned WORD_W     = $clog2(REG_COUNT);
    localparam int unsigned CISR_W     = 6;
    localparam int unsigned SR_IRQ_W   = 5;

    // item kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    // access widths
    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;

    // channel routing in mode register bits 9:8
    localparam logic [1:0] CH_NORMAL = 2'd0;
    localparam logic [1:0] CH_ECHO   = 2'd1;
    localparam logic [1:0] CH_LLOOP  = 2'd2;
    localparam logic [1:0] CH_RLOOP  = 2'd3;

    // register word map
    localparam logic [WORD_W-1:0] W_CR    = WORD_W'(0);
    localparam logic [WORD_W-1:0] W_MR    = WORD_W'(1);
    localparam logic [WORD_W-1:0] W_IER   = WORD_W'(2);
    localparam logic [WORD_W-1:0] W_IDR   = WORD_W'(3);
    localparam logic [WORD_W-1:0] W_IMR   = WORD_W'(4);
    localparam logic [WORD_W-1:0] W_CISR  = WORD_W'(5);
    localparam logic [WORD_W-1:0] W_BRGR  = WORD_W'(6);
    localparam logic [WORD_W-1:0] W_RTRIG = WORD_W'(8);
    localparam logic [WORD_W-1:0] W_SR    = WORD_W'(11);
    localparam logic [WORD_W-1:0] W_DATA  = WORD_W'(12);
    localparam logic [WORD_W-1:0] W_TTRIG = WORD_W'(17);

    // control register bits
    localparam int unsigned CR_RXRST = 0;
    localparam int unsigned CR_TXRST = 1;
    localparam int unsigned CR_RXEN  = 2;
    localparam int unsigned CR_RXDIS = 3;
    localparam int unsigned CR_TXEN  = 4;
    localparam int unsigned CR_TXDIS = 5;

    // status register bits
    localparam int unsigned SR_RTRIG  = 0;
    localparam int unsigned SR_REMPTY = 1;
    localparam int unsigned SR_RFUL   = 2;
    localparam int unsigned SR_TEMPTY = 3;
    localparam int unsigned SR_TFUL   = 4;

    // channel interrupt status bits
    localparam int unsigned CISR_ROVR = 5;

    // reset values
    localparam logic [31:0] CR_RESET    = 32'h0000_0128;
    localparam logic [31:0] SR_RESET    = 32'h0000_000A;
    localparam logic [31:0] RTRIG_RESET = 32'h0000_0020;
    localparam logic [31:0] BRGR_RESET  = 32'h0000_000F;
    localparam logic [31:0] TTRIG_RESET = 32'h0000_0020;

    // where the read data of an item comes from
    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_REG   = 2'd1,
        SEL_PLAIN = 2'd2,
        SEL_FIFO  = 2'd3
    } t_rd_sel;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [1:0]  access_width;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        write_error;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_level;
        logic        rx_space;
    } t_out_item;

    // reset value of a register kept in the plain register ram
    function automatic logic [31:0] plain_reset(input logic [WORD_W-1:0] w);
        logic [31:0] v;
        v = '0;
        if (w == W_BRGR) begin
            v = BRGR_RESET;
        end else if (w == W_TTRIG) begin
            v = TTRIG_RESET;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/urxf_ram.sv */
// ============================================================================
// urxf_ram
// Generic single-port-write, single-port-read ram with registered read data.
// ============================================================================
`default_nettype none

module urxf_ram #(
    parameter  int unsigned WIDTH  = 8,
    parameter  int unsigned DEPTH  = 64,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/uart_registers_with_rx_fifo_unit.sv */
// ============================================================================
// uart_registers_with_rx_fifo_unit
// Uart register file with a receive fifo, interrupt mask and status.
// ============================================================================
// Usage:
// - input channel (i_in_valid, o_in_stall, i_in_item) carries bus reads,
//   bus writes and bytes arriving from the serial line, one per transfer
// - output channel (o_out_valid, i_out_stall, o_out_item) returns exactly
//   one result per input transfer, in order: read data, write error,
//   transmitted byte, interrupt level and receive space
// - an item is taken every cycle while o_in_stall is low; its result passes
//   through stage 1 (the ram read) and then the stage 2 output register
// - control and status registers live in flops and are updated in the
//   cycle of the transfer; the receive bytes sit in a fifo ram and the
//   plain registers (baud, timeouts, modem, ...) in a small register ram,
//   both read through a registered ram port into the output stage
// - each item does one ram access at most, so a read always sees the
//   write of the item before it without forwarding
// - when the receiver stalls, the two result stages fill and then
//   o_in_stall rises; nothing is dropped
// - synchronous reset loads the register reset values, empties the fifo
//   and marks the plain register ram as holding reset values
// ============================================================================
`default_nettype none

module uart_registers_with_rx_fifo_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire urxf_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output urxf_pkg::t_out_item       o_out_item
);

    // control and status registers
    logic [31:0] r_cr, n_cr;
    logic [31:0] r_mr, n_mr;
    logic [31:0] r_imr, n_imr;
    logic [31:0] r_rtrig, n_rtrig;
    logic [31:0] r_sr, n_sr;
    logic [urxf_pkg::CISR_W-1:0] r_cisr, n_cisr;
    logic r_irq, n_irq;

    // fifo pointers
    logic [urxf_pkg::PTR_W-1:0]  r_head, n_head;
    logic [urxf_pkg::PTR_W-1:0]  r_tail, n_tail;
    logic [urxf_pkg::FILL_W-1:0] r_fill, n_fill;

    // plain register ram entries written since reset
    logic [urxf_pkg::REG_COUNT-1:0] r_plain_vld, n_plain_vld;

    // pipeline
    logic                r_s1_valid;
    urxf_pkg::t_out_item r_s1_item, n_s1_item;
    urxf_pkg::t_rd_sel   r_s1_sel, n_s1_sel;
    logic [1:0]          r_s1_width;
    logic                r_s2_valid;
    urxf_pkg::t_out_item r_s2_item;
    urxf_pkg::t_out_item s1_out;
    logic                s2_load;
    logic                acc;

    // decode
    logic [9:0]                  word_full;
    logic [urxf_pkg::WORD_W-1:0] word;
    logic                        in_range;
    logic [31:0]                 src;
    logic [1:0]                  chmode;
    logic                        rx_on;
    logic                        tx_on;
    logic                        do_push;
    logic                        do_pop;
    logic                        pop_hit;
    logic                        cr_wr;
    logic                        refresh;
    logic [7:0]                  push_data;
    logic                        fifo_we;
    logic                        plain_we;
    logic                        plain_re;
    logic [7:0]                  fifo_rdata;
    logic [31:0]                 plain_rdata;

    function automatic logic [31:0] lane_mask(input logic [1:0] w);
        logic [31:0] m;
        m = 32'hFFFF_FFFF;
        if (w == urxf_pkg::WIDTH_BYTE) begin
            m = 32'h0000_00FF;
        end else if (w == urxf_pkg::WIDTH_HALF) begin
            m = 32'h0000_FFFF;
        end
        return m;
    endfunction

    // handshake: stall only when both result stages are held
    assign s2_load    = !r_s2_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s2_load;
    assign acc        = i_in_valid && !o_in_stall;

    assign word_full = i_in_item.address[11:2];
    assign word      = word_full[urxf_pkg::WORD_W-1:0];
    assign in_range  = word_full < 10'(urxf_pkg::REG_COUNT);
    assign src       = i_in_item.write_data & lane_mask(i_in_item.access_width);
    assign chmode    = r_mr[9:8];
    assign rx_on     = r_cr[urxf_pkg::CR_RXEN] && !r_cr[urxf_pkg::CR_RXDIS];
    assign tx_on     = r_cr[urxf_pkg::CR_TXEN] && !r_cr[urxf_pkg::CR_TXDIS];

    // item decode and register update
    always_comb begin
        n_cr        = r_cr;
        n_mr        = r_mr;
        n_imr       = r_imr;
        n_rtrig     = r_rtrig;
        n_sr        = r_sr;
        n_cisr      = r_cisr;
        n_irq       = r_irq;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_plain_vld = r_plain_vld;
        n_s1_item   = '0;
        n_s1_sel    = urxf_pkg::SEL_ZERO;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        pop_hit     = 1'b0;
        cr_wr       = 1'b0;
        refresh     = 1'b0;
        push_data   = i_in_item.rx_byte;
        fifo_we     = 1'b0;
        plain_we    = 1'b0;
        plain_re    = 1'b0;

        if (acc) begin
            unique case (i_in_item.mode)
                urxf_pkg::MODE_READ: begin
                    if (in_range) begin
                        unique case (word)
                            urxf_pkg::W_DATA: begin
                                do_pop = rx_on;
                            end
                            urxf_pkg::W_CR: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = r_cr;
                            end
                            urxf_pkg::W_MR: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = r_mr;
                            end
                            urxf_pkg::W_IMR: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = r_imr;
                            end
                            urxf_pkg::W_CISR: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = 32'(r_cisr);
                            end
                            urxf_pkg::W_RTRIG: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = r_rtrig;
                            end
                            urxf_pkg::W_SR: begin
                                n_s1_sel            = urxf_pkg::SEL_REG;
                                n_s1_item.read_data = r_sr;
                            end
                            urxf_pkg::W_IER, urxf_pkg::W_IDR: begin
                                n_s1_sel = urxf_pkg::SEL_ZERO;
                            end
                            default: begin
                                // unwritten entries read as their reset value
                                if (r_plain_vld[word]) begin
                                    n_s1_sel = urxf_pkg::SEL_PLAIN;
                                    plain_re = 1'b1;
                                end else begin
                                    n_s1_sel            = urxf_pkg::SEL_REG;
                                    n_s1_item.read_data = urxf_pkg::plain_reset(word);
                                end
                            end
                        endcase
                    end
                end
                urxf_pkg::MODE_WRITE: begin
                    if (!in_range) begin
                        n_s1_item.write_error = 1'b1;
                    end else begin
                        refresh = 1'b1;
                        unique case (word)
                            urxf_pkg::W_IER:  n_imr = r_imr | src;
                            urxf_pkg::W_IDR:  n_imr = r_imr & ~src;
                            urxf_pkg::W_IMR:  n_imr = r_imr;
                            urxf_pkg::W_CISR: begin
                                n_cisr = r_cisr & ~src[urxf_pkg::CISR_W-1:0];
                            end
                            urxf_pkg::W_DATA: begin
                                if (chmode == urxf_pkg::CH_NORMAL) begin
                                    if (tx_on) begin
                                        n_s1_item.tx_valid = 1'b1;
                                        n_s1_item.tx_byte  = src[7:0];
                                    end
                                end else if (chmode == urxf_pkg::CH_LLOOP) begin
                                    do_push   = rx_on;
                                    push_data = src[7:0];
                                end
                            end
                            urxf_pkg::W_CR: begin
                                n_cr  = src;
                                cr_wr = 1'b1;
                            end
                            urxf_pkg::W_MR:    n_mr = src;
                            urxf_pkg::W_RTRIG: n_rtrig = src;
                            urxf_pkg::W_SR:    n_sr = src;
                            default: begin
                                plain_we          = 1'b1;
                                n_plain_vld[word] = 1'b1;
                            end
                        endcase
                    end
                end
                urxf_pkg::MODE_LINE: begin
                    // line byte routing: normal and echo fill the fifo,
                    // echo and remote loopback send it back out
                    if (chmode == urxf_pkg::CH_NORMAL || chmode == urxf_pkg::CH_ECHO) begin
                        do_push = rx_on;
                    end
                    if ((chmode == urxf_pkg::CH_RLOOP ||
                         (chmode == urxf_pkg::CH_ECHO && rx_on)) && tx_on) begin
                        n_s1_item.tx_valid = 1'b1;
                        n_s1_item.tx_byte  = i_in_item.rx_byte;
                    end
                end
                default: begin
                end
            endcase
        end

        // fifo pop
        if (do_pop) begin
            n_sr[urxf_pkg::SR_RFUL] = 1'b0;
            if (r_fill != '0) begin
                pop_hit  = 1'b1;
                n_s1_sel = urxf_pkg::SEL_FIFO;
                n_head   = (r_head == urxf_pkg::PTR_W'(urxf_pkg::FIFO_DEPTH - 1)) ?
                           '0 : r_head + 1'b1;
                n_fill   = r_fill - 1'b1;
            end
            if (n_fill == '0) begin
                n_sr[urxf_pkg::SR_REMPTY] = 1'b1;
            end
            if (32'(n_fill) < r_rtrig) begin
                n_sr[urxf_pkg::SR_RTRIG] = 1'b0;
            end
            refresh = 1'b1;
        end

        // fifo push, overrun when full
        if (do_push) begin
            n_sr[urxf_pkg::SR_REMPTY] = 1'b0;
            if (r_fill == urxf_pkg::FILL_W'(urxf_pkg::FIFO_DEPTH)) begin
                n_cisr[urxf_pkg::CISR_ROVR] = 1'b1;
            end else begin
                fifo_we = 1'b1;
                n_tail  = (r_tail == urxf_pkg::PTR_W'(urxf_pkg::FIFO_DEPTH - 1)) ?
                          '0 : r_tail + 1'b1;
                n_fill  = r_fill + 1'b1;
                if (n_fill == urxf_pkg::FILL_W'(urxf_pkg::FIFO_DEPTH)) begin
                    n_sr[urxf_pkg::SR_RFUL] = 1'b1;
                end
            end
            if (32'(n_fill) >= r_rtrig) begin
                n_sr[urxf_pkg::SR_RTRIG] = 1'b1;
            end
            refresh = 1'b1;
        end

        // control write: self-clearing tx and rx resets
        if (cr_wr) begin
            if (src[urxf_pkg::CR_TXRST]) begin
                n_sr[urxf_pkg::SR_TEMPTY] = 1'b1;
                n_sr[urxf_pkg::SR_TFUL]   = 1'b0;
            end
            if (src[urxf_pkg::CR_RXRST]) begin
                n_head                    = '0;
                n_tail                    = '0;
                n_fill                    = '0;
                n_sr[urxf_pkg::SR_REMPTY] = 1'b1;
                n_sr[urxf_pkg::SR_RFUL]   = 1'b0;
            end
            n_cr[urxf_pkg::CR_TXRST] = 1'b0;
            n_cr[urxf_pkg::CR_RXRST] = 1'b0;
            if (n_cr[urxf_pkg::CR_TXEN] && !n_cr[urxf_pkg::CR_TXDIS]) begin
                n_sr[urxf_pkg::SR_TEMPTY] = 1'b1;
            end
        end

        // latch status into interrupt status and recompute the line
        if (refresh) begin
            n_cisr = n_cisr | urxf_pkg::CISR_W'(n_sr[urxf_pkg::SR_IRQ_W-1:0]);
            n_irq  = |(n_imr[urxf_pkg::CISR_W-1:0] & n_cisr);
        end

        n_s1_item.irq_level = n_irq;
        n_s1_item.rx_space  = (n_fill != urxf_pkg::FILL_W'(urxf_pkg::FIFO_DEPTH));
    end

    // receive byte store
    urxf_ram #(
        .WIDTH (8),
        .DEPTH (urxf_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (r_tail),
        .i_wdata (push_data),
        .i_re    (pop_hit),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    // plain register words
    urxf_ram #(
        .WIDTH (32),
        .DEPTH (urxf_pkg::REG_COUNT)
    ) u_plain_ram (
        .i_clk   (i_clk),
        .i_we    (plain_we),
        .i_waddr (word),
        .i_wdata (src),
        .i_re    (plain_re),
        .i_raddr (word),
        .o_rdata (plain_rdata)
    );

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr        <= urxf_pkg::CR_RESET;
            r_mr        <= '0;
            r_imr       <= '0;
            r_rtrig     <= urxf_pkg::RTRIG_RESET;
            r_sr        <= urxf_pkg::SR_RESET;
            r_cisr      <= '0;
            r_irq       <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_plain_vld <= '0;
        end else begin
            r_cr        <= n_cr;
            r_mr        <= n_mr;
            r_imr       <= n_imr;
            r_rtrig     <= n_rtrig;
            r_sr        <= n_sr;
            r_cisr      <= n_cisr;
            r_irq       <= n_irq;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_plain_vld <= n_plain_vld;
        end
    end

    // stage 1: waits for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= acc;
        end
        if (acc) begin
            r_s1_item  <= n_s1_item;
            r_s1_sel   <= n_s1_sel;
            r_s1_width <= i_in_item.access_width;
        end
    end

    // read data selection and lane masking
    always_comb begin
        s1_out = r_s1_item;
        unique case (r_s1_sel)
            urxf_pkg::SEL_ZERO:  s1_out.read_data = '0;
            urxf_pkg::SEL_REG:   s1_out.read_data = r_s1_item.read_data;
            urxf_pkg::SEL_PLAIN: s1_out.read_data = plain_rdata;
            urxf_pkg::SEL_FIFO:  s1_out.read_data = 32'(fifo_rdata);
            default:             s1_out.read_data = '0;
        endcase
        s1_out.read_data = s1_out.read_data & lane_mask(r_s1_width);
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_item <= s1_out;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_item  = r_s2_item;

    // fill count never passes the fifo depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= urxf_pkg::FILL_W'(urxf_pkg::FIFO_DEPTH))
        else $error("fifo fill count beyond depth");

    // empty or full fifo has head and tail on the same entry
    a_ptr_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == urxf_pkg::FILL_W'(urxf_pkg::FIFO_DEPTH))
        |-> (r_head == r_tail))
        else $error("fifo pointers out of step with fill count");

    // a pop of a filled fifo takes exactly one byte
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_hit |=> (r_fill == urxf_pkg::FILL_W'($past(r_fill) - 1'b1)))
        else $error("fifo pop did not lower the fill count by one");

    // interrupt line follows mask and channel status
    a_irq_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == |(r_imr[urxf_pkg::CISR_W-1:0] & r_cisr))
        else $error("interrupt line out of step with mask and status");

endmodule

`default_nettype wire
